/* hw/rtl/artt_pkg.sv */
// Shared types and constants of the address region translation table.
package artt_pkg;

    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 64;
    localparam int FIELD_W   = 64;
    localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EXISTS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FINISH
    } state_t;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [SLOT_W-1:0]    slot_t;

    // One stored region as it sits in the table memory.
    typedef struct packed {
        addr_t recorded_base;
        addr_t actual_base;
        addr_t region_size;
    } entry_t;

    // Control from the sequencer to the match unit.
    typedef struct packed {
        logic  start;
        logic  en;
        slot_t idx;
        logic  entry_valid;
    } scan_ctrl_t;

    // What one pass over the table has found.
    typedef struct packed {
        logic  exact_found;
        slot_t exact_idx;
        addr_t exact_actual;
        logic  range_found;
        addr_t range_actual;
        addr_t range_offset;
        logic  free_found;
        slot_t free_idx;
    } scan_result_t;

endpackage

/* hw/rtl/artt_req_if.sv */
// Request channel: operation words going into the translation table.
interface artt_req_if;
    import artt_pkg::*;

    logic                valid;
    logic                ready;
    op_t                 operation;
    logic [FIELD_W-1:0]  recorded_address;
    logic [FIELD_W-1:0]  actual_base;
    logic [FIELD_W-1:0]  region_size;

    modport source (
        output valid,
        output operation,
        output recorded_address,
        output actual_base,
        output region_size,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  recorded_address,
        input  actual_base,
        input  region_size,
        output ready
    );
endinterface

/* hw/rtl/artt_rsp_if.sv */
// Response channel: result words coming out of the translation table.
interface artt_rsp_if;
    import artt_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic                hit;
    logic                by_range;
    logic [FIELD_W-1:0]  translated_address;

    modport source (
        output valid,
        output status,
        output hit,
        output by_range,
        output translated_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  hit,
        input  by_range,
        input  translated_address,
        output ready
    );
endinterface

/* hw/rtl/address_region_translation_table.sv */
// Top level of the address region translation table: sequencer, valid bits and output register.
//
//   Channel    Modport  Word carries
//   ---------  -------  ------------------------------------------------------
//   request    sink     operation, recorded_address, actual_base, region_size
//   response   source   status, hit, by_range, translated_address
//
// Each request word is answered after one pass over the table, paced by the
// table memory's single read port: the sequencer reads one entry per cycle,
// and the match unit finds the exact match, the first range match and the
// first free slot in that one pass.
// Reset clears the valid bits, so the table is empty at once; there is no
// clearing pass, and the memory contents of an invalid slot are read but never used in a match.
// A new request word is taken as soon as the sequencer is idle, even while the
// previous response word still waits in the output register. If that register
// is still full when a pass ends, the sequencer holds until it is taken.
module address_region_translation_table (
    input  logic      clk,
    input  logic      rst_n,
    artt_req_if.sink  request,
    artt_rsp_if.source response
);
    import artt_pkg::*;

    state_t state_reg, state_next;

    op_t    op_reg;
    addr_t  key_reg;
    addr_t  act_reg;
    addr_t  size_reg;

    slot_t  rd_idx_reg, rd_idx_next;
    logic   eval_reg, eval_next;
    slot_t  eval_idx_reg;

    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic    rsp_valid_reg, rsp_valid_next;
    status_t rsp_status_reg;
    logic    rsp_hit_reg;
    logic    rsp_by_range_reg;
    addr_t   rsp_xlat_reg;

    logic         accept;
    logic         ram_re;
    logic         ram_we;
    slot_t        ram_waddr;
    entry_t       ram_wdata;
    entry_t       ram_rdata;
    logic         last_read;
    logic         rsp_load;

    scan_ctrl_t   scan_ctrl;
    scan_result_t scan_res;

    status_t fin_status;
    logic    fin_hit;
    logic    fin_by_range;
    addr_t   fin_xlat;
    logic    fin_set;
    logic    fin_clear;
    slot_t   fin_slot;

    assign accept    = request.valid && request.ready;
    assign last_read = (rd_idx_reg == slot_t'(ENTRIES - 1));
    assign rsp_load  = (state_reg == ST_FINISH) && (!rsp_valid_reg || response.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_read)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        request.ready = 1'b0;
        ram_re        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re = 1'b1;
            end
            ST_TAIL:
            begin
                ram_re = 1'b0;
            end
            ST_FINISH:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                request.ready = 1'b0;
            end
        endcase
    end

    // The read address walks the table; the match unit sees each entry in the
    // cycle after its read, together with the valid bit of the same slot.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (accept)
        begin
            rd_idx_next = '0;
        end
        else if (ram_re && !last_read)
        begin
            rd_idx_next = rd_idx_reg + slot_t'(1);
        end
        eval_next = ram_re;
    end

    always_comb
    begin
        scan_ctrl.start       = accept;
        scan_ctrl.en          = eval_reg;
        scan_ctrl.idx         = eval_idx_reg;
        scan_ctrl.entry_valid = valid_reg[eval_idx_reg];
    end

    artt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    artt_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .entry  (ram_rdata),
        .key    (key_reg),
        .result (scan_res)
    );

    // Result of the pass. Add updates an existing base before it takes a free
    // slot; lookup prefers an exact base over a range match.
    always_comb
    begin
        fin_status   = STATUS_NOT_FOUND;
        fin_hit      = 1'b0;
        fin_by_range = 1'b0;
        fin_xlat     = '0;
        fin_set      = 1'b0;
        fin_clear    = 1'b0;
        fin_slot     = scan_res.exact_idx;
        unique case (op_reg)
            OP_ADD:
            begin
                if (scan_res.exact_found)
                begin
                    fin_status = STATUS_OK;
                    fin_set    = 1'b1;
                end
                else if (scan_res.free_found)
                begin
                    fin_status = STATUS_OK;
                    fin_set    = 1'b1;
                    fin_slot   = scan_res.free_idx;
                end
                else
                begin
                    fin_status = STATUS_FULL;
                end
            end
            OP_LOOKUP:
            begin
                fin_xlat = key_reg;
                if (scan_res.exact_found)
                begin
                    fin_status = STATUS_OK;
                    fin_hit    = 1'b1;
                    fin_xlat   = scan_res.exact_actual;
                end
                else if (scan_res.range_found)
                begin
                    fin_status   = STATUS_OK;
                    fin_hit      = 1'b1;
                    fin_by_range = 1'b1;
                    fin_xlat     = scan_res.range_actual + scan_res.range_offset;
                end
            end
            OP_REMOVE:
            begin
                if (scan_res.exact_found)
                begin
                    fin_status = STATUS_OK;
                    fin_clear  = 1'b1;
                end
            end
            OP_EXISTS:
            begin
                if (scan_res.exact_found)
                begin
                    fin_status = STATUS_OK;
                    fin_hit    = 1'b1;
                end
            end
            default:
            begin
                fin_status = STATUS_NOT_FOUND;
            end
        endcase
    end

    // The table is changed in the same cycle the response word is loaded, so
    // each request word writes at most once.
    always_comb
    begin
        ram_we                  = rsp_load && fin_set;
        ram_waddr               = fin_slot;
        ram_wdata.recorded_base = key_reg;
        ram_wdata.actual_base   = act_reg;
        ram_wdata.region_size   = size_reg;
        valid_next              = valid_reg;
        if (rsp_load && fin_set)
        begin
            valid_next[fin_slot] = 1'b1;
        end
        else if (rsp_load && fin_clear)
        begin
            valid_next[fin_slot] = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            eval_reg      <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            eval_reg      <= eval_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= rd_idx_reg;
        if (accept)
        begin
            op_reg   <= request.operation;
            key_reg  <= request.recorded_address[ADDR_BITS-1:0];
            act_reg  <= request.actual_base[ADDR_BITS-1:0];
            size_reg <= request.region_size[ADDR_BITS-1:0];
        end
        if (rsp_load)
        begin
            rsp_status_reg   <= fin_status;
            rsp_hit_reg      <= fin_hit;
            rsp_by_range_reg <= fin_by_range;
            rsp_xlat_reg     <= fin_xlat;
        end
    end

    assign response.valid              = rsp_valid_reg;
    assign response.status             = rsp_status_reg;
    assign response.hit                = rsp_hit_reg;
    assign response.by_range           = rsp_by_range_reg;
    assign response.translated_address = FIELD_W'(rsp_xlat_reg);

endmodule

/* hw/rtl/artt_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
module artt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/artt_scan.sv */
// Match unit: checks one table entry per cycle and keeps the first hits.
module artt_scan (
    input  logic                    clk,
    input  logic                    rst_n,
    input  artt_pkg::scan_ctrl_t    ctrl,
    input  artt_pkg::entry_t        entry,
    input  artt_pkg::addr_t         key,
    output artt_pkg::scan_result_t  result
);
    import artt_pkg::*;

    logic [ADDR_BITS:0] span_end;
    logic               exact_hit;
    logic               range_hit;
    addr_t              offset;

    logic  exact_found_reg, exact_found_next;
    slot_t exact_idx_reg, exact_idx_next;
    addr_t exact_actual_reg, exact_actual_next;
    logic  range_found_reg, range_found_next;
    addr_t range_actual_reg, range_actual_next;
    addr_t range_offset_reg, range_offset_next;
    logic  free_found_reg, free_found_next;
    slot_t free_idx_reg, free_idx_next;

    // A range whose end carries out past the address space never matches.
    always_comb
    begin
        span_end  = {1'b0, entry.recorded_base} + {1'b0, entry.region_size};
        offset    = key - entry.recorded_base;
        exact_hit = ctrl.entry_valid && (entry.recorded_base == key);
        range_hit = ctrl.entry_valid && !span_end[ADDR_BITS]
                    && (key >= entry.recorded_base)
                    && (key < span_end[ADDR_BITS-1:0]);
    end

    always_comb
    begin
        exact_found_next  = exact_found_reg;
        exact_idx_next    = exact_idx_reg;
        exact_actual_next = exact_actual_reg;
        range_found_next  = range_found_reg;
        range_actual_next = range_actual_reg;
        range_offset_next = range_offset_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        if (ctrl.start)
        begin
            exact_found_next = 1'b0;
            range_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else if (ctrl.en)
        begin
            if (exact_hit && !exact_found_reg)
            begin
                exact_found_next  = 1'b1;
                exact_idx_next    = ctrl.idx;
                exact_actual_next = entry.actual_base;
            end
            if (range_hit && !range_found_reg)
            begin
                range_found_next  = 1'b1;
                range_actual_next = entry.actual_base;
                range_offset_next = offset;
            end
            if (!ctrl.entry_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ctrl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_found_reg <= 1'b0;
            range_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            exact_found_reg <= exact_found_next;
            range_found_reg <= range_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exact_idx_reg    <= exact_idx_next;
        exact_actual_reg <= exact_actual_next;
        range_actual_reg <= range_actual_next;
        range_offset_reg <= range_offset_next;
        free_idx_reg     <= free_idx_next;
    end

    always_comb
    begin
        result.exact_found  = exact_found_reg;
        result.exact_idx    = exact_idx_reg;
        result.exact_actual = exact_actual_reg;
        result.range_found  = range_found_reg;
        result.range_actual = range_actual_reg;
        result.range_offset = range_offset_reg;
        result.free_found   = free_found_reg;
        result.free_idx     = free_idx_reg;
    end

endmodule

/* hw/rtl/artt_checker.sv */
// Port-level checker for the address region translation table, with its bind.
module artt_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input artt_pkg::status_t      rsp_status,
    input logic                   rsp_hit,
    input logic                   rsp_by_range,
    input logic [artt_pkg::FIELD_W-1:0] rsp_xlat
);
    import artt_pkg::*;

    // One word at a time: after a request is taken, ready drops.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a word is in progress");

    // A range hit is always a successful hit.
    a_range_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_by_range |-> rsp_hit && (rsp_status == STATUS_OK))
        else $error("range hit without a successful hit");

    // A full table on add reports nothing else.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_FULL)
        |-> !rsp_hit && !rsp_by_range && (rsp_xlat == '0))
        else $error("full status with hit or address set");

    // A stalled response word holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
        && $stable(rsp_hit) && $stable(rsp_by_range) && $stable(rsp_xlat))
        else $error("response word changed while stalled");

endmodule

bind address_region_translation_table artt_checker u_artt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .rsp_valid    (response.valid),
    .rsp_ready    (response.ready),
    .rsp_status   (response.status),
    .rsp_hit      (response.hit),
    .rsp_by_range (response.by_range),
    .rsp_xlat     (response.translated_address)
);

/* tb/sv/address_region_translation_table_tb.sv */
// Self-checking testbench of the address region translation table.
`timescale 1ns / 1ps

module address_region_translation_table_tb;
    import artt_pkg::*;

    // One request word as the sender puts it on the request channel.
    typedef struct {
        op_t                operation;
        logic [FIELD_W-1:0] recorded_address;
        logic [FIELD_W-1:0] actual_base;
        logic [FIELD_W-1:0] region_size;
    } request_word_t;

    // One response word as the table is expected to return it.
    typedef struct {
        status_t            status;
        logic               hit;
        logic               by_range;
        logic [FIELD_W-1:0] translated_address;
    } response_word_t;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int PHASES          = 4;
    localparam int KEY_POOL        = 24;
    // The tail wait allows for more than two passes over the table.
    localparam int DRAIN_CYCLES    = 2 * (ENTRIES + 2) + 8;
    // Far above the slowest correct run, even with the worst idling.
    localparam int TIMEOUT_NS      = 10_000_000;

    logic clk;
    logic rst_n;

    artt_req_if request_if();
    artt_rsp_if response_if();

    address_region_translation_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_if),
        .response (response_if)
    );

    // Words waiting to be driven, and responses the table owes us, oldest first.
    request_word_t  pending_requests[$];
    response_word_t expected_responses[$];

    // Shadow copy of the region table, updated as each request word is accepted.
    bit    shadow_valid[ENTRIES];
    addr_t shadow_recorded[ENTRIES];
    addr_t shadow_actual[ENTRIES];
    addr_t shadow_size[ENTRIES];

    // Per-phase idling: percent of cycles the sender holds off, and the
    // receiver drops ready.
    int sender_idle_pct;
    int receiver_stall_pct;

    // High from the cycle a word is put on the channel until it is accepted.
    bit word_in_flight;
    int error_count;

    request_word_t  drive_word;
    request_word_t  taken_word;
    response_word_t seen_response;
    response_word_t want_response;

    // Key pool for the random part: bases that are reused so that updates,
    // removes of live entries, overlaps and a full table all come up often.
    logic [63:0] pool_base[KEY_POOL];
    logic [63:0] pool_size[KEY_POOL];

    // The clock runs free from time zero.
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Computes the response to one request word and applies its effect to
    // the shadow table. Exact matches and free slots both go to the lowest
    // index, and so does the range match when regions overlap.
    function automatic response_word_t translate_request(request_word_t w);
        response_word_t r;
        addr_t key;
        addr_t region_end;
        int    exact_slot;
        int    free_slot;
        int    range_slot;
        int    i;
        key        = w.recorded_address[ADDR_BITS-1:0];
        exact_slot = -1;
        free_slot  = -1;
        range_slot = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (exact_slot < 0 && shadow_valid[i] && shadow_recorded[i] == key)
                exact_slot = i;
            if (free_slot < 0 && !shadow_valid[i])
                free_slot = i;
            if (shadow_valid[i])
            begin
                // The end wraps at the address width; a wrapped end lies
                // below the base, so such a slot can never hit by range.
                region_end = shadow_recorded[i] + shadow_size[i];
                if (range_slot < 0 && key >= shadow_recorded[i] && key < region_end)
                    range_slot = i;
            end
        end

        r.status             = STATUS_NOT_FOUND;
        r.hit                = 1'b0;
        r.by_range           = 1'b0;
        r.translated_address = '0;

        case (w.operation)
            OP_ADD:
            begin
                // Update in place when the base is known, else take a free slot.
                if (exact_slot < 0)
                    exact_slot = free_slot;
                if (exact_slot < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    shadow_valid[exact_slot]    = 1'b1;
                    shadow_recorded[exact_slot] = key;
                    shadow_actual[exact_slot]   = w.actual_base[ADDR_BITS-1:0];
                    shadow_size[exact_slot]     = w.region_size[ADDR_BITS-1:0];
                    r.status = STATUS_OK;
                end
            end
            OP_LOOKUP:
            begin
                // A miss hands the address back untouched.
                r.translated_address = FIELD_W'(key);
                if (exact_slot >= 0)
                begin
                    r.status             = STATUS_OK;
                    r.hit                = 1'b1;
                    r.translated_address = FIELD_W'(shadow_actual[exact_slot]);
                end
                else if (range_slot >= 0)
                begin
                    r.status             = STATUS_OK;
                    r.hit                = 1'b1;
                    r.by_range           = 1'b1;
                    r.translated_address = FIELD_W'(addr_t'(shadow_actual[range_slot]
                                           + (key - shadow_recorded[range_slot])));
                end
            end
            OP_REMOVE:
            begin
                if (exact_slot >= 0)
                begin
                    shadow_valid[exact_slot] = 1'b0;
                    r.status = STATUS_OK;
                end
            end
            default:
            begin
                if (exact_slot >= 0)
                begin
                    r.status = STATUS_OK;
                    r.hit    = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_request(op_t op, logic [63:0] rec, logic [63:0] act,
                                 logic [63:0] size);
        request_word_t w;
        w.operation        = op;
        w.recorded_address = rec;
        w.actual_base      = act;
        w.region_size      = size;
        pending_requests.push_back(w);
    endtask

    // Returns once every queued word has been accepted and answered.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || word_in_flight ||
               expected_responses.size() != 0)
            @(negedge clk);
    endtask

    // Hand-picked words that walk through each corner of the table.
    task automatic queue_directed();
        int i;
        // Everything misses on an empty table.
        queue_request(OP_LOOKUP, 64'h0, 64'h0, 64'h0);
        queue_request(OP_EXISTS, 64'h5, 64'h0, 64'h0);
        // A zero-size region hits only on its exact base.
        queue_request(OP_ADD,    64'h0, '1, 64'h0);
        queue_request(OP_LOOKUP, 64'h0, 64'h0, 64'h0);
        queue_request(OP_LOOKUP, 64'h1, 64'h0, 64'h0);
        // Range hit whose translation wraps past the top of the address space,
        // then the first address past the end, which misses.
        queue_request(OP_ADD,    64'h1000, 64'hFFFF_FFFF_FFFF_FFF0, 64'h100);
        queue_request(OP_LOOKUP, 64'h10FF, 64'h0, 64'h0);
        queue_request(OP_LOOKUP, 64'h1100, 64'h0, 64'h0);
        // Overlapping region in a higher slot: the lower slot still wins.
        queue_request(OP_ADD,    64'h1080, 64'h5000, 64'h1000);
        queue_request(OP_LOOKUP, 64'h1090, 64'h0, 64'h0);
        // Updating the first region shrinks it, so the overlap now goes
        // to the second one.
        queue_request(OP_ADD,    64'h1000, 64'h7000, 64'h10);
        queue_request(OP_LOOKUP, 64'h1090, 64'h0, 64'h0);
        // A region whose end wraps never hits by range.
        queue_request(OP_ADD,    64'hFFFF_FFFF_FFFF_FF00, 64'hA5A5_5A5A_0F0F_F0F0, 64'h200);
        queue_request(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF10, 64'h0, 64'h0);
        // Top address with every size bit set: exact match only.
        queue_request(OP_ADD,    '1, 64'h0, '1);
        queue_request(OP_LOOKUP, '1, '1, '1);
        // Exists and remove on a live base, then the same base is gone.
        queue_request(OP_EXISTS, 64'h1080, 64'h0, 64'h0);
        queue_request(OP_REMOVE, 64'h1080, 64'h0, 64'h0);
        queue_request(OP_EXISTS, 64'h1080, 64'h0, 64'h0);
        // Four slots are live here; twelve more fill the table and the
        // last add finds it full.
        for (i = 0; i < 13; i++)
            queue_request(OP_ADD, 64'h2000_0000_0000_0000 + 64'(i) * 64'h100,
                          rand64(), 64'h40);
    endtask

    // Fresh set of bases for a phase: a cluster of overlapping regions,
    // some near zero, some just under the top, and some anywhere.
    task automatic build_pool();
        logic [63:0] origin;
        int i;
        origin = rand64();
        for (i = 0; i < KEY_POOL; i++)
        begin
            case (i % 4)
                0, 1: pool_base[i] = origin + 64'($urandom_range(0, 'h8000));
                2:    pool_base[i] = (i % 8 == 2) ? 64'($urandom_range(0, 'h4000))
                                                  : 64'h0 - 64'($urandom_range(1, 'h4000));
                default: pool_base[i] = rand64();
            endcase
            pool_size[i] = 64'h0;
        end
    endtask

    function automatic logic [63:0] pick_size(logic [63:0] base);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 64'h0;
        else if (r < 65)
            return 64'($urandom_range(1, 'h2000));
        else if (r < 85)
            return rand64();
        // Just long enough for the end to wrap past the top.
        return (~base) + 64'h1 + 64'($urandom_range(0, 'h1000));
    endfunction

    // Lookup address aimed at one pool region: its base, somewhere inside or up to
    // a quarter of its size past it, its last byte, just past its end, or anywhere at all.
    function automatic logic [63:0] pick_lookup_address();
        int k;
        int r;
        logic [63:0] offset;
        k = $urandom_range(KEY_POOL - 1);
        r = $urandom_range(99);
        if (r < 35)
            return pool_base[k];
        if (r < 70)
        begin
            if (pool_size[k] <= 64'h10000)
                offset = 64'($urandom_range(0, 32'(pool_size[k] + pool_size[k] / 4)));
            else
                offset = rand64() % pool_size[k];
            return pool_base[k] + offset;
        end
        if (r < 80)
            return pool_base[k] + pool_size[k];
        if (r < 88)
            return pool_base[k] + pool_size[k] - 64'h1;
        return rand64();
    endfunction

    // Mostly well-formed traffic on pool bases, with a tenth of pure noise.
    task automatic queue_random(int count);
        int n;
        int r;
        int k;
        logic [63:0] size;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            k = $urandom_range(KEY_POOL - 1);
            if (r < 10)
                queue_request(op_t'($urandom_range(3)), rand64(), rand64(), rand64());
            else if (r < 40)
            begin
                size = pick_size(pool_base[k]);
                pool_size[k] = size;
                queue_request(OP_ADD, pool_base[k], rand64(), size);
            end
            else if (r < 75)
                queue_request(OP_LOOKUP, pick_lookup_address(), rand64(), rand64());
            else if (r < 88)
                queue_request(OP_REMOVE, pool_base[k], rand64(), rand64());
            else
                queue_request(OP_EXISTS, pool_base[k], rand64(), rand64());
        end
    endtask

    // Driver: at each falling edge, once the last word has been taken, put
    // the next pending word on the channel or leave valid low.
    always @(negedge clk)
    begin
        if (!rst_n)
            request_if.valid <= 1'b0;
        else if (!word_in_flight)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                drive_word = pending_requests.pop_front();
                request_if.operation        <= drive_word.operation;
                request_if.recorded_address <= drive_word.recorded_address;
                request_if.actual_base      <= drive_word.actual_base;
                request_if.region_size      <= drive_word.region_size;
                request_if.valid            <= 1'b1;
                word_in_flight = 1'b1;
            end
            else
                request_if.valid <= 1'b0;
        end
    end

    // The receiver drops ready at random, as the phase asks.
    always @(negedge clk)
    begin
        response_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Monitor: at each rising edge, predict for an accepted request word and
    // check an accepted response word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_if.valid && request_if.ready)
            begin
                taken_word.operation        = request_if.operation;
                taken_word.recorded_address = request_if.recorded_address;
                taken_word.actual_base      = request_if.actual_base;
                taken_word.region_size      = request_if.region_size;
                expected_responses.push_back(translate_request(taken_word));
                word_in_flight = 1'b0;
            end
            if (response_if.valid && response_if.ready)
            begin
                seen_response.status             = response_if.status;
                seen_response.hit                = response_if.hit;
                seen_response.by_range           = response_if.by_range;
                seen_response.translated_address = response_if.translated_address;
                if (expected_responses.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected response status=%0d hit=%0b by_range=%0b xlat=%h",
                             $time, seen_response.status, seen_response.hit,
                             seen_response.by_range, seen_response.translated_address);
                end
                else
                begin
                    want_response = expected_responses.pop_front();
                    if (seen_response.status !== want_response.status ||
                        seen_response.hit !== want_response.hit ||
                        seen_response.by_range !== want_response.by_range ||
                        seen_response.translated_address !==
                            want_response.translated_address)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected status=%0d hit=%0b by_range=%0b xlat=%h",
                                 $time, want_response.status, want_response.hit,
                                 want_response.by_range, want_response.translated_address);
                        $display("%0t:          actual status=%0d hit=%0b by_range=%0b xlat=%h",
                                 $time, seen_response.status, seen_response.hit,
                                 seen_response.by_range, seen_response.translated_address);
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed words, then one random phase per idling
    // pattern: none, a slow sender, a slow receiver, and both at once.
    initial
    begin : stimulus
        int phase;
        int sender_pcts[PHASES];
        int receiver_pcts[PHASES];
        sender_pcts   = '{0, 88, 0, 38};
        receiver_pcts = '{0, 0, 88, 38};
        error_count        = 0;
        word_in_flight     = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n                       = 1'b0;
        request_if.valid            = 1'b0;
        request_if.operation        = OP_ADD;
        request_if.recorded_address = '0;
        request_if.actual_base      = '0;
        request_if.region_size      = '0;
        response_if.ready           = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            sender_idle_pct    = sender_pcts[phase];
            receiver_stall_pct = receiver_pcts[phase];
            build_pool();
            queue_random(ITEMS_PER_PHASE);
            wait_drained();
        end

        // Give a stray extra response time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0)
            $display("address_region_translation_table test passed");
        else
            $display("address_region_translation_table test failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("address_region_translation_table test failed");
        $finish;
    end

endmodule
